// ----- src/joystick_calibrated_axis_mapper_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the calibrated axis mapper
// Shorthand for clocked checks on clock and reset of the including module.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_CALIBRATED_AXIS_MAPPER_CORE_MACROS_SVH
`define JOYSTICK_CALIBRATED_AXIS_MAPPER_CORE_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define JCAM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define JCAM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/jcam_pkg.sv -----
// ----------------------------------------------------------------------------
// jcam_pkg
// Shared types, codes and reset calibration values for the axis mapper.
// ----------------------------------------------------------------------------
package jcam_pkg;

   localparam int unsigned SAMPLE_BITS_DEFAULT = 12;
   localparam int unsigned AXES                = 4;
   localparam int unsigned AXIS_BITS           = 2;
   localparam int unsigned RIGHT_FIRST         = 2;  // axes from here on are inverted
   localparam int unsigned MODE_BITS           = 2;
   localparam int unsigned CSR_INDEX_BITS      = 2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_RUN_MODE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CAL_STEP = 2'd1;

   // run modes
   localparam logic [MODE_BITS-1:0] MODE_MAP = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_CAL = 2'd1;

   // calibration steps
   localparam logic [MODE_BITS-1:0] STEP_CENTRE = 2'd0;
   localparam logic [MODE_BITS-1:0] STEP_TRACK  = 2'd1;

   typedef int unsigned cal_table_type [AXES];

   localparam cal_table_type LOW_RESET    = '{630, 350, 100, 680};
   localparam cal_table_type CENTRE_RESET = '{1960, 1650, 1565, 2070};
   localparam cal_table_type HIGH_RESET   = '{3400, 2960, 3050, 3420};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

   typedef enum logic [1:0] {
      BASE_ZERO,
      BASE_MID,
      BASE_FULL
   } base_type;

   // segment decision for one axis: result = base +/- quotient
   typedef struct packed {
      logic     direct;   // no division, quotient counts as zero
      logic     negate;   // subtract quotient from base
      base_type base;
   } seg_ctl_type;

endpackage

// ----- src/jcam_seg.sv -----
// ----------------------------------------------------------------------------
// jcam_seg
// Picks the calibration segment of one sample and forms dividend and divisor.
// ----------------------------------------------------------------------------
module jcam_seg #(
   parameter int unsigned SAMPLE_BITS = jcam_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic [SAMPLE_BITS-1:0]   sample,
   input  logic [SAMPLE_BITS-1:0]   cal_lo,
   input  logic [SAMPLE_BITS-1:0]   cal_mid,
   input  logic [SAMPLE_BITS-1:0]   cal_hi,
   input  logic                     invert,
   output jcam_pkg::seg_ctl_type    ctl,
   output logic [2*SAMPLE_BITS-1:0] dividend,
   output logic [SAMPLE_BITS-1:0]   divisor
);

   logic [SAMPLE_BITS-1:0]   delta;
   logic [SAMPLE_BITS-1:0]   run;
   logic                     lower;
   logic                     span_mid;
   logic [2*SAMPLE_BITS-1:0] delta_wide;

   assign lower    = (sample <= cal_mid);
   // span is the mid code when rising below centre or falling above it
   assign span_mid = lower ^ invert;

   always_comb begin
      delta      = '0;
      run        = '1;
      ctl.direct = 1'b0;
      ctl.negate = invert;
      ctl.base   = jcam_pkg::BASE_ZERO;
      priority if (sample <= cal_lo) begin
         ctl.direct = 1'b1;
         ctl.negate = 1'b0;
         ctl.base   = invert ? jcam_pkg::BASE_FULL : jcam_pkg::BASE_ZERO;
      end else if (sample >= cal_hi) begin
         ctl.direct = 1'b1;
         ctl.negate = 1'b0;
         ctl.base   = invert ? jcam_pkg::BASE_ZERO : jcam_pkg::BASE_FULL;
      end else if (lower) begin
         delta    = sample - cal_lo;
         run      = cal_mid - cal_lo;
         ctl.base = invert ? jcam_pkg::BASE_FULL : jcam_pkg::BASE_ZERO;
      end else begin
         delta    = sample - cal_mid;
         run      = cal_hi - cal_mid;
         ctl.base = jcam_pkg::BASE_MID;
      end
   end

   // delta times span, span being 2^(n-1) or 2^(n-1)-1
   assign delta_wide = {{SAMPLE_BITS{1'b0}}, delta};
   assign dividend   = (delta_wide << (SAMPLE_BITS - 1)) - (span_mid ? '0 : delta_wide);
   assign divisor    = run;

endmodule

// ----- src/jcam_div.sv -----
// ----------------------------------------------------------------------------
// jcam_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module jcam_div #(
   parameter int unsigned SAMPLE_BITS = jcam_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [2*SAMPLE_BITS-1:0] dividend,
   input  logic [SAMPLE_BITS-1:0]   divisor,
   output logic                     done,
   output logic [SAMPLE_BITS-1:0]   quotient
);

   localparam int unsigned CNT_BITS = $clog2(SAMPLE_BITS + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] shf_ff, shf_in;
   logic [SAMPLE_BITS-1:0] dvs_ff, dvs_in;

   logic [SAMPLE_BITS:0]   partial;
   logic [SAMPLE_BITS:0]   diff;
   logic                   fits;

   assign partial = {rem_ff, shf_ff[SAMPLE_BITS-1]};
   assign fits    = (partial >= {1'b0, dvs_ff});
   assign diff    = partial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         // upper half is already below the divisor
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend[2*SAMPLE_BITS-1:SAMPLE_BITS];
         shf_in  = dividend[SAMPLE_BITS-1:0];
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[SAMPLE_BITS-1:0] : partial[SAMPLE_BITS-1:0];
         shf_in = {shf_ff[SAMPLE_BITS-2:0], fits};
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(SAMPLE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = shf_ff;

endmodule

// ----- src/joystick_calibrated_axis_mapper_core.sv -----
// ----------------------------------------------------------------------------
// joystick_calibrated_axis_mapper_core
// Three-point calibration of two sticks, with a calibrate pass-through mode.
// ----------------------------------------------------------------------------
// Input channel req_: four raw samples, taken when req_valid is high and
// req_stall is low. Result channel rsp_: four axis values and is_raw, taken
// when rsp_valid is high and rsp_stall is low. Register port csr_: index 0
// run_mode, index 1 cal_step; csr_ready is always high.
// Map mode: the four axes share one serial divider, one quotient bit per
// cycle. An axis that falls in a linear segment passes through the setup
// and divide states; an axis clamped at an end is settled in setup with no
// division. Calibrate mode: the result passes through the deliver state into
// the output register, and the calibration registers update at the transfer.
// Idle mode: no result.
// One item is worked on at a time; req_stall is high while it is in flight.
// A finished result sits in the output register while the next item is
// taken; a stalled receiver holds the block only once a second result is done.
// Reset loads the factory calibration, clears the trackers and both
// registers, and empties the output register.
// ----------------------------------------------------------------------------
`include "joystick_calibrated_axis_mapper_core_macros.svh"

module joystick_calibrated_axis_mapper_core #(
   parameter int unsigned SAMPLE_BITS = jcam_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [SAMPLE_BITS-1:0]              req_raw_left_x,
   input  logic [SAMPLE_BITS-1:0]              req_raw_left_y,
   input  logic [SAMPLE_BITS-1:0]              req_raw_right_x,
   input  logic [SAMPLE_BITS-1:0]              req_raw_right_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [SAMPLE_BITS-1:0]              rsp_axis_left_x,
   output logic [SAMPLE_BITS-1:0]              rsp_axis_left_y,
   output logic [SAMPLE_BITS-1:0]              rsp_axis_right_x,
   output logic [SAMPLE_BITS-1:0]              rsp_axis_right_y,
   output logic                                rsp_is_raw,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [jcam_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [jcam_pkg::MODE_BITS-1:0]      csr_wdata
);

   localparam int unsigned AXES      = jcam_pkg::AXES;
   localparam int unsigned AXIS_BITS = jcam_pkg::AXIS_BITS;

   typedef logic [SAMPLE_BITS-1:0] sample_type;

   jcam_pkg::state_type              state_ff, state_in;
   logic [jcam_pkg::MODE_BITS-1:0]   run_mode_ff, run_mode_in;
   logic [jcam_pkg::MODE_BITS-1:0]   cal_step_ff, cal_step_in;
   logic [AXIS_BITS-1:0]             axis_ff, axis_in;
   sample_type                       lane_ff [AXES];
   sample_type                       lane_in [AXES];
   logic                             is_raw_ff, is_raw_in;
   jcam_pkg::seg_ctl_type            ctl_ff, ctl_in;
   sample_type                       cal_low_ff [AXES];
   sample_type                       cal_low_in [AXES];
   sample_type                       cal_centre_ff [AXES];
   sample_type                       cal_centre_in [AXES];
   sample_type                       cal_high_ff [AXES];
   sample_type                       cal_high_in [AXES];
   sample_type                       track_low_ff [AXES];
   sample_type                       track_low_in [AXES];
   sample_type                       track_high_ff [AXES];
   sample_type                       track_high_in [AXES];
   logic                             rsp_valid_ff, rsp_valid_in;
   sample_type                       rsp_lane_ff [AXES];
   sample_type                       rsp_lane_in [AXES];
   logic                             rsp_is_raw_ff, rsp_is_raw_in;

   sample_type                       req_sample [AXES];
   logic                             req_accept;
   logic                             csr_write;
   logic                             rsp_free;
   logic                             last_axis;
   logic                             lane_shift;
   logic                             div_start;
   logic                             div_done;
   logic                             load_out;
   logic                             invert;
   jcam_pkg::seg_ctl_type            seg_ctl;
   jcam_pkg::seg_ctl_type            cur_ctl;
   logic [2*SAMPLE_BITS-1:0]         seg_dividend;
   sample_type                       seg_divisor;
   sample_type                       quotient;
   sample_type                       step_q;
   sample_type                       base_val;
   sample_type                       axis_val;

   assign req_sample[0] = req_raw_left_x;
   assign req_sample[1] = req_raw_left_y;
   assign req_sample[2] = req_raw_right_x;
   assign req_sample[3] = req_raw_right_y;

   assign req_stall  = (state_ff != jcam_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign last_axis  = (axis_ff == AXIS_BITS'(AXES - 1));
   assign invert     = (axis_ff >= AXIS_BITS'(jcam_pkg::RIGHT_FIRST));

   jcam_seg #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_seg (
      .sample   (lane_ff[0]),
      .cal_lo   (cal_low_ff[axis_ff]),
      .cal_mid  (cal_centre_ff[axis_ff]),
      .cal_hi   (cal_high_ff[axis_ff]),
      .invert   (invert),
      .ctl      (seg_ctl),
      .dividend (seg_dividend),
      .divisor  (seg_divisor)
   );

   jcam_div #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (seg_dividend),
      .divisor  (seg_divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jcam_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (run_mode_ff == jcam_pkg::MODE_MAP) begin
                  state_in = jcam_pkg::ST_SETUP;
               end else if (run_mode_ff == jcam_pkg::MODE_CAL) begin
                  state_in = jcam_pkg::ST_DELIVER;
               end
            end
         end
         jcam_pkg::ST_SETUP: begin
            if (!seg_ctl.direct) begin
               state_in = jcam_pkg::ST_DIVIDE;
            end else if (last_axis) begin
               state_in = jcam_pkg::ST_DELIVER;
            end
         end
         jcam_pkg::ST_DIVIDE: begin
            if (div_done) begin
               state_in = last_axis ? jcam_pkg::ST_DELIVER : jcam_pkg::ST_SETUP;
            end
         end
         jcam_pkg::ST_DELIVER: begin
            if (rsp_free) begin
               state_in = jcam_pkg::ST_IDLE;
            end
         end
         default: state_in = jcam_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      lane_shift = 1'b0;
      div_start  = 1'b0;
      load_out   = 1'b0;
      unique case (state_ff)
         jcam_pkg::ST_IDLE: begin
         end
         jcam_pkg::ST_SETUP: begin
            lane_shift = seg_ctl.direct;
            div_start  = !seg_ctl.direct;
         end
         jcam_pkg::ST_DIVIDE: begin
            lane_shift = div_done;
         end
         jcam_pkg::ST_DELIVER: begin
            load_out = rsp_free;
         end
         default: begin
         end
      endcase
   end

   // axis value = base +/- quotient
   assign cur_ctl = (state_ff == jcam_pkg::ST_DIVIDE) ? ctl_ff : seg_ctl;
   assign step_q  = (state_ff == jcam_pkg::ST_DIVIDE) ? quotient : '0;

   always_comb begin
      unique case (cur_ctl.base)
         jcam_pkg::BASE_ZERO: base_val = '0;
         jcam_pkg::BASE_MID:  base_val = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
         jcam_pkg::BASE_FULL: base_val = '1;
         default:             base_val = '0;
      endcase
   end

   assign axis_val = cur_ctl.negate ? (base_val - step_q) : (base_val + step_q);

   // working lanes: samples shift out at the bottom, results shift in at the top
   always_comb begin
      lane_in   = lane_ff;
      axis_in   = axis_ff;
      is_raw_in = is_raw_ff;
      ctl_in    = ctl_ff;
      if (req_accept) begin
         lane_in   = req_sample;
         axis_in   = '0;
         is_raw_in = (run_mode_ff == jcam_pkg::MODE_CAL);
      end else if (lane_shift) begin
         for (int i = 0; i < AXES - 1; i++) begin
            lane_in[i] = lane_ff[i+1];
         end
         lane_in[AXES-1] = axis_val;
         axis_in         = axis_ff + AXIS_BITS'(1);
      end
      if (div_start) begin
         ctl_in = seg_ctl;
      end
   end

   // calibration capture
   always_comb begin
      cal_low_in    = cal_low_ff;
      cal_centre_in = cal_centre_ff;
      cal_high_in   = cal_high_ff;
      track_low_in  = track_low_ff;
      track_high_in = track_high_ff;
      if (req_accept && run_mode_ff == jcam_pkg::MODE_CAL) begin
         for (int i = 0; i < AXES; i++) begin
            if (cal_step_ff == jcam_pkg::STEP_CENTRE) begin
               cal_centre_in[i] = req_sample[i];
               track_low_in[i]  = req_sample[i];
               track_high_in[i] = req_sample[i];
            end else if (cal_step_ff == jcam_pkg::STEP_TRACK) begin
               track_high_in[i] = (req_sample[i] > track_high_ff[i]) ?
                                  req_sample[i] : track_high_ff[i];
               track_low_in[i]  = (req_sample[i] < track_low_ff[i]) ?
                                  req_sample[i] : track_low_ff[i];
               cal_high_in[i]   = track_high_in[i];
               cal_low_in[i]    = track_low_in[i];
            end
         end
      end
   end

   // register writes
   always_comb begin
      run_mode_in = run_mode_ff;
      cal_step_in = cal_step_ff;
      if (csr_write) begin
         unique case (csr_index)
            jcam_pkg::REG_RUN_MODE: run_mode_in = csr_wdata;
            jcam_pkg::REG_CAL_STEP: cal_step_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // output register: load on a free slot, drop valid after the transfer
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_lane_in   = rsp_lane_ff;
      rsp_is_raw_in = rsp_is_raw_ff;
      if (load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_lane_in   = lane_ff;
         rsp_is_raw_in = is_raw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jcam_pkg::ST_IDLE;
         run_mode_ff  <= '0;
         cal_step_ff  <= '0;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            cal_low_ff[i]    <= SAMPLE_BITS'(jcam_pkg::LOW_RESET[i]);
            cal_centre_ff[i] <= SAMPLE_BITS'(jcam_pkg::CENTRE_RESET[i]);
            cal_high_ff[i]   <= SAMPLE_BITS'(jcam_pkg::HIGH_RESET[i]);
            track_low_ff[i]  <= '0;
            track_high_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         run_mode_ff   <= run_mode_in;
         cal_step_ff   <= cal_step_in;
         axis_ff       <= axis_in;
         rsp_valid_ff  <= rsp_valid_in;
         cal_low_ff    <= cal_low_in;
         cal_centre_ff <= cal_centre_in;
         cal_high_ff   <= cal_high_in;
         track_low_ff  <= track_low_in;
         track_high_ff <= track_high_in;
      end
   end

   always_ff @(posedge clock) begin
      lane_ff       <= lane_in;
      is_raw_ff     <= is_raw_in;
      ctl_ff        <= ctl_in;
      rsp_lane_ff   <= rsp_lane_in;
      rsp_is_raw_ff <= rsp_is_raw_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_axis_left_x  = rsp_lane_ff[0];
   assign rsp_axis_left_y  = rsp_lane_ff[1];
   assign rsp_axis_right_x = rsp_lane_ff[2];
   assign rsp_axis_right_y = rsp_lane_ff[3];
   assign rsp_is_raw       = rsp_is_raw_ff;

   `JCAM_ASSERT_NEXT(a_map_starts_at_first_axis,
      req_valid && !req_stall && run_mode_ff == jcam_pkg::MODE_MAP,
      state_ff == jcam_pkg::ST_SETUP && axis_ff == '0,
      "map transfer did not start at the first axis")
   `JCAM_ASSERT_SAME(a_div_done_in_divide,
      div_done,
      state_ff == jcam_pkg::ST_DIVIDE,
      "divider finished outside the divide state")
   `JCAM_ASSERT_NEXT(a_deliver_waits_for_slot,
      state_ff == jcam_pkg::ST_DELIVER && rsp_valid_ff && rsp_stall,
      state_ff == jcam_pkg::ST_DELIVER && rsp_valid_ff,
      "result left deliver while output register was blocked")

endmodule
